FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MCSRL_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mcsrl assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define MCSRL_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mcsrl assertion failed");

`endif

FILE: rtl/mcsrl_pkg.sv
`default_nettype none

package mcsrl_pkg;

  localparam int MOTORS        = 10;
  localparam int DEFAULT_RATE  = 10;
  localparam int START_ENABLED = 1;

  localparam int SPEED_LIMIT   = 127;
  localparam int NO_LIMIT_RATE = 256;

  // channel index width (at least one bit)
  localparam int CH_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  localparam logic [8:0] RESET_RATE =
    (START_ENABLED != 0) ? 9'(DEFAULT_RATE) : 9'(NO_LIMIT_RATE);

  localparam logic [1:0] CMD_SET_TARGET = 2'd0;
  localparam logic [1:0] CMD_FORCE      = 2'd1;
  localparam logic [1:0] CMD_SET_RATE   = 2'd2;
  localparam logic [1:0] CMD_TICK       = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // classified command word handed from front to back
  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        chan;
    logic signed [7:0] speed;
    logic [8:0]        rate;
    logic              present;
  } word_t;

endpackage

`default_nettype wire

FILE: rtl/mcsrl_queue.sv
`default_nettype none

module mcsrl_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push_valid,
  output logic                push_ready,
  input  mcsrl_pkg::word_t    push_word,
  output logic                pop_valid,
  input  wire                 pop_ready,
  output mcsrl_pkg::word_t    pop_word
);

  mcsrl_pkg::word_t slots [mcsrl_pkg::QUEUE_DEPTH];
  logic [mcsrl_pkg::QPTR_W-1:0] wr_ptr;
  logic [mcsrl_pkg::QPTR_W-1:0] rd_ptr;
  logic [mcsrl_pkg::QPTR_W:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (count != (mcsrl_pkg::QPTR_W+1)'(mcsrl_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mcsrl_front.sv
`default_nettype none

module mcsrl_front (
  input  wire                 cmd_valid,
  output logic                cmd_ready,
  input  wire  [1:0]          command,
  input  wire  [3:0]          channel,
  input  wire  signed [15:0]  speed,
  input  wire  [8:0]          slew_rate,
  output logic                push_valid,
  input  wire                 push_ready,
  output mcsrl_pkg::word_t    push_word
);

  logic signed [7:0] speed_clamped;
  logic [8:0]        rate_sat;

  always_comb begin
    if (speed > 16'(mcsrl_pkg::SPEED_LIMIT)) begin
      speed_clamped = 8'(mcsrl_pkg::SPEED_LIMIT);
    end else if (speed < -16'(mcsrl_pkg::SPEED_LIMIT)) begin
      speed_clamped = -8'(mcsrl_pkg::SPEED_LIMIT);
    end else begin
      speed_clamped = speed[7:0];
    end
  end

  assign rate_sat = (slew_rate > 9'(mcsrl_pkg::NO_LIMIT_RATE)) ?
                    9'(mcsrl_pkg::NO_LIMIT_RATE) : slew_rate;

  assign cmd_ready  = push_ready;
  assign push_valid = cmd_valid;

  always_comb begin
    push_word.cmd     = command;
    push_word.chan    = channel;
    push_word.speed   = speed_clamped;
    push_word.rate    = rate_sat;
    push_word.present = ({1'b0, channel} < 5'(mcsrl_pkg::MOTORS));
  end

endmodule

`default_nettype wire

FILE: rtl/mcsrl_back.sv
`default_nettype none

module mcsrl_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 pop_valid,
  output logic                pop_ready,
  input  mcsrl_pkg::word_t    pop_word,
  output logic                res_valid,
  input  wire                 res_ready,
  output logic [3:0]          out_channel,
  output logic signed [7:0]   drive,
  output logic                last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic                          state;
  logic [mcsrl_pkg::CH_W-1:0]    idx;
  logic signed [7:0]             target_tab [mcsrl_pkg::MOTORS];
  logic signed [7:0]             drive_tab  [mcsrl_pkg::MOTORS];
  logic [8:0]                    rate_tab   [mcsrl_pkg::MOTORS];

  logic                          out_free;
  logic                          take;
  logic                          tick_step;
  logic [mcsrl_pkg::CH_W-1:0]    wchan;

  logic signed [7:0]             t_cur;
  logic signed [7:0]             d_cur;
  logic [8:0]                    r_cur;
  logic signed [8:0]             diff;
  logic [8:0]                    mag;
  logic [8:0]                    step;
  logic signed [7:0]             d_new;

  assign out_free  = !res_valid || res_ready;
  assign pop_ready = (state == ST_IDLE) && out_free;
  assign take      = pop_valid && pop_ready;
  assign tick_step = (state == ST_TICK) && out_free;
  assign wchan     = pop_word.chan[mcsrl_pkg::CH_W-1:0];

  // one channel of the tick sequence
  assign t_cur = target_tab[idx];
  assign d_cur = drive_tab[idx];
  assign r_cur = rate_tab[idx];
  assign diff  = {t_cur[7], t_cur} - {d_cur[7], d_cur};
  assign mag   = diff[8] ? 9'(-diff) : 9'(diff);
  assign step  = (mag < r_cur) ? mag : r_cur;

  always_comb begin
    if (diff > 0) begin
      d_new = d_cur + signed'(step[7:0]);
    end else if (diff < 0) begin
      d_new = d_cur - signed'(step[7:0]);
    end else begin
      d_new = d_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < mcsrl_pkg::MOTORS; i++) begin
        target_tab[i] <= '0;
        drive_tab[i]  <= '0;
        rate_tab[i]   <= mcsrl_pkg::RESET_RATE;
      end
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (pop_word.cmd == mcsrl_pkg::CMD_TICK) begin
              state <= ST_TICK;
              idx   <= '0;
            end else begin
              res_valid   <= 1'b1;
              out_channel <= pop_word.chan;
              last        <= 1'b1;
              if (!pop_word.present) begin
                drive <= '0;
              end else begin
                case (pop_word.cmd)
                  mcsrl_pkg::CMD_SET_TARGET: begin
                    target_tab[wchan] <= pop_word.speed;
                    drive             <= drive_tab[wchan];
                  end
                  mcsrl_pkg::CMD_FORCE: begin
                    target_tab[wchan] <= pop_word.speed;
                    drive_tab[wchan]  <= pop_word.speed;
                    drive             <= pop_word.speed;
                  end
                  default: begin
                    rate_tab[wchan] <= pop_word.rate;
                    drive           <= drive_tab[wchan];
                  end
                endcase
              end
            end
          end
        end
        default: begin
          if (tick_step) begin
            drive_tab[idx] <= d_new;
            res_valid      <= 1'b1;
            out_channel    <= 4'(idx);
            drive          <= d_new;
            if (idx == mcsrl_pkg::CH_W'(mcsrl_pkg::MOTORS - 1)) begin
              last  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              last <= 1'b0;
              idx  <= idx + 1'b1;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/multi_channel_slew_rate_limiter_unit.sv
// Channel  Handshake              Word fields
// command  cmd_valid / cmd_ready  command, channel, speed, slew_rate
// result   res_valid / res_ready  out_channel, drive, last
//
// Set target, force and set rate each give one result word.
// Tick enters the tick state, then steps one channel per unstalled cycle
// through the shared step unit, one word each, last on the final channel.
// Synchronous active-high rst clears targets and drives, loads default rates.
// A two-word queue lets commands enter while the back end or result stalls.
`default_nettype none

module multi_channel_slew_rate_limiter_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  wire  [1:0]         command,
  input  wire  [3:0]         channel,
  input  wire  signed [15:0] speed,
  input  wire  [8:0]         slew_rate,
  output logic               res_valid,
  input  wire                res_ready,
  output logic [3:0]         out_channel,
  output logic signed [7:0]  drive,
  output logic               last
);

  logic             push_valid;
  logic             push_ready;
  mcsrl_pkg::word_t push_word;
  logic             pop_valid;
  logic             pop_ready;
  mcsrl_pkg::word_t pop_word;

  mcsrl_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .command    (command),
    .channel    (channel),
    .speed      (speed),
    .slew_rate  (slew_rate),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  mcsrl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  mcsrl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_word    (pop_word),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_channel (out_channel),
    .drive       (drive),
    .last        (last)
  );

endmodule

`default_nettype wire

FILE: rtl/mcsrl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mcsrl_checker (
  input wire               clk,
  input wire               rst,
  input wire               res_valid,
  input wire               res_ready,
  input wire [3:0]         out_channel,
  input wire signed [7:0]  drive,
  input wire               last
);

  logic absent;

  assign absent = ({1'b0, out_channel} >= 5'(mcsrl_pkg::MOTORS));

  `MCSRL_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)
  `MCSRL_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(drive) && $stable(last))
  `MCSRL_ASSERT_IMP(a_drive_range, res_valid, drive != -8'sd128)
  `MCSRL_ASSERT_IMP(a_mid_tick, res_valid && !last, out_channel < 4'(mcsrl_pkg::MOTORS - 1))
  `MCSRL_ASSERT_IMP(a_absent_zero, res_valid && absent, drive == 8'sd0)

endmodule

bind multi_channel_slew_rate_limiter_unit mcsrl_checker u_chk (.*);

`default_nettype wire
